// File: rtl/base64url_canonical_decoder_unit_assert.svh
// ---------------------------------------------------------------------------
// base64url decoder assertion macros
// concurrent checks clocked on clk, disabled while rst_n is low
// ---------------------------------------------------------------------------
`ifndef BASE64URL_CANONICAL_DECODER_UNIT_ASSERT_SVH
`define BASE64URL_CANONICAL_DECODER_UNIT_ASSERT_SVH

// same-cycle implication
`define B64U_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("b64u assertion failed");

// next-cycle implication
`define B64U_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("b64u assertion failed");

`endif

// File: rtl/b64u_pkg.sv
// ---------------------------------------------------------------------------
// b64u_pkg
// shared types, status codes and the character map of the base64url decoder
// ---------------------------------------------------------------------------
package b64u_pkg;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_BAD_CHAR = 3'd1,
    ST_BAD_LEN  = 3'd2,
    ST_NONCANON = 3'd3,
    ST_OVERFLOW = 3'd4
  } status_t;

  localparam logic [7:0] CH_UA    = 8'h41;
  localparam logic [7:0] CH_UZ    = 8'h5A;
  localparam logic [7:0] CH_LA    = 8'h61;
  localparam logic [7:0] CH_LZ    = 8'h7A;
  localparam logic [7:0] CH_D0    = 8'h30;
  localparam logic [7:0] CH_D9    = 8'h39;
  localparam logic [7:0] CH_DASH  = 8'h2D;
  localparam logic [7:0] CH_UNDER = 8'h5F;

  // results caused by one item, delivered one per cycle while out_tready is high
  typedef struct packed {
    logic [2:0][7:0] bytes;
    logic [1:0]      nres;
    logic            data_ok;
    logic            fin;
    status_t         status;
    logic [15:0]     total;
  } group_t;

  // {ok, sextet}
  function automatic logic [6:0] sextet_of(input logic [7:0] c);
    logic [7:0] d;
    d = 8'd0;
    if (c >= CH_UA && c <= CH_UZ) begin
      d = c - CH_UA;
      return {1'b1, d[5:0]};
    end else if (c >= CH_LA && c <= CH_LZ) begin
      d = c - CH_LA + 8'd26;
      return {1'b1, d[5:0]};
    end else if (c >= CH_D0 && c <= CH_D9) begin
      d = c - CH_D0 + 8'd52;
      return {1'b1, d[5:0]};
    end else if (c == CH_DASH) begin
      return {1'b1, 6'd62};
    end else if (c == CH_UNDER) begin
      return {1'b1, 6'd63};
    end
    return 7'd0;
  endfunction

endpackage

// File: rtl/base64url_canonical_decoder_unit.sv
// ---------------------------------------------------------------------------
// base64url_canonical_decoder_unit
// unpadded base64url decoder, one character per item, canonical tail check
// ---------------------------------------------------------------------------
// in_* carries one character per item, in_tlast on the final character.
// out_* carries decoded bytes; out_tuser is byte_valid, out_tlast ends the
//   token and then out_tdata holds status and total byte count.
// cfg_wen/cfg_wdata set the byte capacity (reset 65535); write when idle.
// latency: the first result of an item is shown the cycle after acceptance.
// throughput: an item that gives no result is taken every cycle; one that
//   gives results is taken once the result register is empty or drains its
//   last result. a group's three results drain while the next characters
//   are taken, so a steady stream has no gap.
// stall: with out_tready low the result register holds and in_tready drops
//   for an item that gives results, so nothing is lost.
// reset: synchronous active-low rst_n clears token state, empties the
//   result register and restores the capacity to 65535.
// after an error the token's later characters give no result; the final
//   character gives one result with byte_valid low and the status.
// ---------------------------------------------------------------------------
module base64url_canonical_decoder_unit #(
  parameter int COUNT_BITS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wen,
  input  logic [15:0] cfg_wdata,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] char_code
  input  logic        in_tlast,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // [7:0] data_byte, [10:8] status, [26:11] total_bytes
  output logic        out_tuser,  // [0] byte_valid
  output logic        out_tlast
);

  b64u_pkg::group_t grp;
  logic             in_acc;
  logic             free;
  logic [7:0]       o_byte;
  logic [2:0]       o_status;
  logic [15:0]      o_total;

  assign in_tready = free || (grp.nres == 2'd0);
  assign in_acc    = in_tvalid && in_tready;

  b64u_decode_core #(
    .COUNT_BITS (COUNT_BITS)
  ) u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wen   (cfg_wen),
    .cfg_wdata (cfg_wdata),
    .in_acc    (in_acc),
    .in_char   (in_tdata),
    .in_fin    (in_tlast),
    .grp       (grp)
  );

  b64u_out_ser u_ser (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (in_acc && (grp.nres != 2'd0)),
    .grp_in     (grp),
    .free       (free),
    .out_tready (out_tready),
    .out_tvalid (out_tvalid),
    .out_byte   (o_byte),
    .out_bvalid (out_tuser),
    .out_last   (out_tlast),
    .out_status (o_status),
    .out_total  (o_total)
  );

  assign out_tdata = {5'd0, o_total, o_status, o_byte};

`include "base64url_canonical_decoder_unit_assert.svh"

  `B64U_ASSERT_IMPL(a_mid_clean, out_tvalid && !out_tlast, out_tdata[26:8] == 19'd0)
  `B64U_ASSERT_IMPL(a_empty_is_last, out_tvalid && !out_tuser, out_tlast)
  `B64U_ASSERT_IMPL(a_empty_is_err, out_tvalid && !out_tuser, out_tdata[10:8] != b64u_pkg::ST_OK)
  `B64U_ASSERT_IMPL(a_idle_ready, !out_tvalid, in_tready)
  `B64U_ASSERT_NEXT(a_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata))

endmodule

// File: rtl/b64u_decode_core.sv
// ---------------------------------------------------------------------------
// b64u_decode_core
// token state, capacity register and group formation for one accepted item per cycle
// ---------------------------------------------------------------------------
module b64u_decode_core #(
  parameter int COUNT_BITS = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_wen,
  input  logic [15:0]       cfg_wdata,
  input  logic              in_acc,
  input  logic [7:0]        in_char,
  input  logic              in_fin,
  output b64u_pkg::group_t  grp
);

  localparam int WB = ((COUNT_BITS > 16) ? COUNT_BITS : 16) + 2;

  logic [15:0]           max_bytes_r;
  logic [17:0]           buf_r, buf_nxt;
  logic [1:0]            pos_r, pos_nxt;
  logic [COUNT_BITS-1:0] cnt_r, cnt_nxt;
  b64u_pkg::status_t     err_r, err_nxt;

  logic [6:0]            sx;
  logic [5:0]            v;
  logic [1:0]            need;
  logic                  fits;
  logic [COUNT_BITS-1:0] cnt_add;
  logic [WB-1:0]         cnt_add_w, cnt_cur_w;
  logic                  fail_now;
  b64u_pkg::status_t     fail_code;
  logic [23:0]           w;

  assign sx        = b64u_pkg::sextet_of(in_char);
  assign v         = sx[5:0];
  assign need      = (pos_r == 2'd3) ? 2'd3 : pos_r;
  assign cnt_cur_w = WB'(cnt_r);
  assign fits      = (cnt_cur_w + WB'(need)) <= WB'(max_bytes_r);
  assign cnt_add   = cnt_r + COUNT_BITS'(need);
  assign cnt_add_w = WB'(cnt_add);
  assign w         = {buf_r, v};

  always_comb begin
    buf_nxt   = buf_r;
    pos_nxt   = pos_r;
    cnt_nxt   = cnt_r;
    err_nxt   = err_r;
    fail_now  = 1'b0;
    fail_code = err_r;
    grp       = '0;
    grp.status = b64u_pkg::ST_OK;

    if (err_r != b64u_pkg::ST_OK) begin
      fail_now = in_fin;
    end else if (!sx[6]) begin
      err_nxt   = b64u_pkg::ST_BAD_CHAR;
      fail_code = b64u_pkg::ST_BAD_CHAR;
      fail_now  = in_fin;
    end else if (pos_r == 2'd3) begin
      if (!fits) begin
        err_nxt   = b64u_pkg::ST_OVERFLOW;
        fail_code = b64u_pkg::ST_OVERFLOW;
        fail_now  = in_fin;
      end else begin
        cnt_nxt     = cnt_add;
        buf_nxt     = '0;
        pos_nxt     = 2'd0;
        grp.bytes   = {w[7:0], w[15:8], w[23:16]};
        grp.nres    = 2'd3;
        grp.data_ok = 1'b1;
        grp.fin     = in_fin;
        grp.total   = in_fin ? cnt_add_w[15:0] : 16'd0;
      end
    end else if (!in_fin) begin
      buf_nxt = w[17:0];
      pos_nxt = pos_r + 2'd1;
    end else if (pos_r == 2'd0) begin
      err_nxt   = b64u_pkg::ST_BAD_LEN;
      fail_code = b64u_pkg::ST_BAD_LEN;
      fail_now  = 1'b1;
    end else if (pos_r == 2'd1) begin
      if ((v & 6'h0f) != 6'd0) begin
        fail_code = b64u_pkg::ST_NONCANON;
        fail_now  = 1'b1;
      end else if (!fits) begin
        fail_code = b64u_pkg::ST_OVERFLOW;
        fail_now  = 1'b1;
      end else begin
        grp.bytes   = {8'd0, 8'd0, buf_r[5:0], v[5:4]};
        grp.nres    = 2'd1;
        grp.data_ok = 1'b1;
        grp.fin     = 1'b1;
        grp.total   = cnt_add_w[15:0];
      end
    end else begin
      if ((v & 6'h03) != 6'd0) begin
        fail_code = b64u_pkg::ST_NONCANON;
        fail_now  = 1'b1;
      end else if (!fits) begin
        fail_code = b64u_pkg::ST_OVERFLOW;
        fail_now  = 1'b1;
      end else begin
        grp.bytes   = {8'd0, buf_r[3:0], v[5:2], buf_r[11:6], buf_r[5:4]};
        grp.nres    = 2'd2;
        grp.data_ok = 1'b1;
        grp.fin     = 1'b1;
        grp.total   = cnt_add_w[15:0];
      end
    end

    if (fail_now) begin
      grp         = '0;
      grp.nres    = 2'd1;
      grp.fin     = 1'b1;
      grp.status  = fail_code;
      grp.total   = cnt_cur_w[15:0];
    end

    // every final item closes the token
    if (in_fin) begin
      buf_nxt = '0;
      pos_nxt = 2'd0;
      cnt_nxt = '0;
      err_nxt = b64u_pkg::ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_bytes_r <= 16'hffff;
      buf_r       <= '0;
      pos_r       <= 2'd0;
      cnt_r       <= '0;
      err_r       <= b64u_pkg::ST_OK;
    end else begin
      if (cfg_wen) begin
        max_bytes_r <= cfg_wdata;
      end
      if (in_acc) begin
        buf_r <= buf_nxt;
        pos_r <= pos_nxt;
        cnt_r <= cnt_nxt;
        err_r <= err_nxt;
      end
    end
  end

endmodule

// File: rtl/b64u_out_ser.sv
// ---------------------------------------------------------------------------
// b64u_out_ser
// result register that hands out a group of up to three results, one a cycle while out_tready is high
// ---------------------------------------------------------------------------
module b64u_out_ser (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             load,
  input  b64u_pkg::group_t grp_in,
  output logic             free,
  input  logic             out_tready,
  output logic             out_tvalid,
  output logic [7:0]       out_byte,
  output logic             out_bvalid,
  output logic             out_last,
  output logic [2:0]       out_status,
  output logic [15:0]      out_total
);

  b64u_pkg::group_t grp_r;
  logic             vld_r, vld_nxt;
  logic [1:0]       beat_r, beat_nxt;
  logic             last_beat;
  logic             take;

  assign last_beat = (beat_r == (grp_r.nres - 2'd1));
  assign take      = vld_r && out_tready;
  assign free      = !vld_r || (out_tready && last_beat);

  assign out_tvalid = vld_r;
  assign out_bvalid = grp_r.data_ok;
  assign out_byte   = grp_r.data_ok ? grp_r.bytes[beat_r] : 8'd0;
  assign out_last   = grp_r.fin && last_beat;
  assign out_status = out_last ? grp_r.status : 3'd0;
  assign out_total  = out_last ? grp_r.total : 16'd0;

  always_comb begin
    vld_nxt  = vld_r;
    beat_nxt = beat_r;
    if (take) begin
      if (last_beat) begin
        vld_nxt  = 1'b0;
        beat_nxt = 2'd0;
      end else begin
        beat_nxt = beat_r + 2'd1;
      end
    end
    if (load) begin
      vld_nxt  = 1'b1;
      beat_nxt = 2'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r  <= 1'b0;
      beat_r <= 2'd0;
    end else begin
      vld_r  <= vld_nxt;
      beat_r <= beat_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      grp_r <= grp_in;
    end
  end

endmodule

// File: tb/base64url_canonical_decoder_unit_test.sv
// ----------------------------------------------------------------------------
// base64url_canonical_decoder_unit_test
// Streams base64url tokens into the decoder one character per item and checks
// every decoded byte and end-of-token status against a cycle-free model of the
// decoder kept in a scoreboard. Covers clean groups and tails, bad characters,
// lone final characters, non-canonical tails and capacity overflow, across
// several capacity settings and random backpressure on both sides.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module base64url_canonical_decoder_unit_test;

  localparam int CYCLE_LIMIT = 300000;
  localparam int SEG_ITEMS   = 32;

  typedef struct packed {
    logic [7:0]  data_byte;
    logic        byte_valid;
    logic        last;
    logic [2:0]  status;
    logic [15:0] total_bytes;
  } decoded_t;

  class b64_token_checker;
    decoded_t            decoded_q[$];
    logic [17:0]         sext_buf;
    logic [1:0]          grp_pos;
    logic [15:0]         nbytes;
    b64u_pkg::status_t   err;
    logic [15:0]         cap;
    int                  errors;

    function new();
      cap = 16'hFFFF;
      errors = 0;
      clear_token();
    endfunction

    function void clear_token();
      sext_buf = '0;
      grp_pos = '0;
      nbytes = '0;
      err = b64u_pkg::ST_OK;
    endfunction

    function void set_cap(logic [15:0] v);
      cap = v;
    endfunction

    function int pending();
      return decoded_q.size();
    endfunction

    function int map_char(logic [7:0] c);
      if (c >= b64u_pkg::CH_UA && c <= b64u_pkg::CH_UZ) return int'(c - b64u_pkg::CH_UA);
      if (c >= b64u_pkg::CH_LA && c <= b64u_pkg::CH_LZ) return int'(c - b64u_pkg::CH_LA) + 26;
      if (c >= b64u_pkg::CH_D0 && c <= b64u_pkg::CH_D9) return int'(c - b64u_pkg::CH_D0) + 52;
      if (c == b64u_pkg::CH_DASH) return 62;
      if (c == b64u_pkg::CH_UNDER) return 63;
      return -1;
    endfunction

    function bit fits(int extra);
      return int'(nbytes) + extra <= int'(cap);
    endfunction

    function void push(logic [7:0] b, logic valid, logic fin, b64u_pkg::status_t st);
      decoded_t r;
      r.data_byte   = valid ? b : 8'd0;
      r.byte_valid  = valid;
      r.last        = fin;
      r.status      = fin ? st : 3'd0;
      r.total_bytes = fin ? nbytes : 16'd0;
      decoded_q.push_back(r);
    endfunction

    function void finish_err();
      push(8'd0, 1'b0, 1'b1, err);
      clear_token();
    endfunction

    function void note_char(logic [7:0] c, logic fin);
      int          v;
      logic [23:0] w;
      logic [5:0]  a, b, d;
      if (err != b64u_pkg::ST_OK) begin
        if (fin) finish_err();
        return;
      end
      v = map_char(c);
      if (v < 0) begin
        err = b64u_pkg::ST_BAD_CHAR;
        if (fin) finish_err();
        return;
      end
      d = v[5:0];
      if (grp_pos == 2'd3) begin
        w = {sext_buf, d};
        if (!fits(3)) begin
          err = b64u_pkg::ST_OVERFLOW;
          if (fin) finish_err();
          return;
        end
        nbytes = nbytes + 16'd3;
        sext_buf = '0;
        grp_pos = '0;
        push(w[23:16], 1'b1, 1'b0, b64u_pkg::ST_OK);
        push(w[15:8], 1'b1, 1'b0, b64u_pkg::ST_OK);
        push(w[7:0], 1'b1, fin, b64u_pkg::ST_OK);
        if (fin) clear_token();
        return;
      end
      if (!fin) begin
        sext_buf = {sext_buf[11:0], d};
        grp_pos = grp_pos + 2'd1;
        return;
      end
      if (grp_pos == 2'd0) begin
        err = b64u_pkg::ST_BAD_LEN;
        finish_err();
      end else if (grp_pos == 2'd1) begin
        a = sext_buf[5:0];
        if (d[3:0] != 4'd0) begin
          err = b64u_pkg::ST_NONCANON;
          finish_err();
        end else if (!fits(1)) begin
          err = b64u_pkg::ST_OVERFLOW;
          finish_err();
        end else begin
          nbytes = nbytes + 16'd1;
          push({a, d[5:4]}, 1'b1, 1'b1, b64u_pkg::ST_OK);
          clear_token();
        end
      end else begin
        a = sext_buf[11:6];
        b = sext_buf[5:0];
        if (d[1:0] != 2'd0) begin
          err = b64u_pkg::ST_NONCANON;
          finish_err();
        end else if (!fits(2)) begin
          err = b64u_pkg::ST_OVERFLOW;
          finish_err();
        end else begin
          nbytes = nbytes + 16'd2;
          push({a, b[5:4]}, 1'b1, 1'b0, b64u_pkg::ST_OK);
          push({b[3:0], d[5:2]}, 1'b1, 1'b1, b64u_pkg::ST_OK);
          clear_token();
        end
      end
    endfunction

    function void check_result(logic [31:0] tdata, logic tuser, logic tlast);
      decoded_t want;
      if (decoded_q.size() == 0) begin
        $error("unexpected result: data %0h valid %0b last %0b", tdata, tuser, tlast);
        errors++;
        return;
      end
      want = decoded_q.pop_front();
      if (tdata[7:0] !== want.data_byte) begin
        $error("data_byte: expected %0h, got %0h", want.data_byte, tdata[7:0]);
        errors++;
      end
      if (tuser !== want.byte_valid) begin
        $error("byte_valid: expected %0b, got %0b", want.byte_valid, tuser);
        errors++;
      end
      if (tlast !== want.last) begin
        $error("last: expected %0b, got %0b", want.last, tlast);
        errors++;
      end
      if (tdata[10:8] !== want.status) begin
        $error("status: expected %0d, got %0d", want.status, tdata[10:8]);
        errors++;
      end
      if (tdata[26:11] !== want.total_bytes) begin
        $error("total_bytes: expected %0d, got %0d", want.total_bytes, tdata[26:11]);
        errors++;
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_wen = 1'b0;
  logic [15:0] cfg_wdata = '0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = '0;   // [7:0] char_code
  logic        in_tlast = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [31:0] out_tdata;       // [7:0] data_byte, [10:8] status, [26:11] total_bytes
  logic        out_tuser;       // [0] byte_valid
  logic        out_tlast;

  b64_token_checker sb;
  int in_gap_pct = 0;
  int out_stall_pct = 0;
  int n_items = 0;
  int cycles = 0;

  base64url_canonical_decoder_unit u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wen    (cfg_wen),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  always @(negedge clk) begin
    out_tready <= ($urandom_range(0, 99) >= out_stall_pct);
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      sb.check_result(out_tdata, out_tuser, out_tlast);
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  function automatic logic [7:0] char_for(int s);
    if (s < 26) return b64u_pkg::CH_UA + 8'(s);
    if (s < 52) return b64u_pkg::CH_LA + 8'(s - 26);
    if (s < 62) return b64u_pkg::CH_D0 + 8'(s - 52);
    if (s == 62) return b64u_pkg::CH_DASH;
    return b64u_pkg::CH_UNDER;
  endfunction

  task automatic send_char(input logic [7:0] c, input logic fin);
    @(negedge clk);
    if (in_gap_pct != 0 && $urandom_range(0, 99) < in_gap_pct) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= c;
    in_tlast <= fin;
    do @(posedge clk); while (!in_tready);
    sb.note_char(c, fin);
    n_items++;
  endtask

  task automatic send_str(input string s);
    for (int i = 0; i < s.len(); i++) send_char(s[i], i == s.len() - 1);
  endtask

  task automatic drain();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_cap(input logic [15:0] v);
    drain();
    @(negedge clk);
    cfg_wen <= 1'b1;
    cfg_wdata <= v;
    @(negedge clk);
    cfg_wen <= 1'b0;
    sb.set_cap(v);
  endtask

  task automatic send_random_token();
    int kind, len, bad_at, s;
    logic [7:0] c;
    kind = $urandom_range(0, 99);
    len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 24) : $urandom_range(1, 8);
    bad_at = (kind >= 70 && kind < 85) ? $urandom_range(0, len - 1) : -1;
    for (int i = 0; i < len; i++) begin
      s = $urandom_range(0, 63);
      // keep most tails canonical
      if (i == len - 1 && $urandom_range(0, 99) < 85) begin
        if (len % 4 == 2) s = s & 48;
        else if (len % 4 == 3) s = s & 60;
      end
      c = char_for(s);
      if (kind >= 85 || i == bad_at) c = 8'($urandom_range(0, 255));
      send_char(c, i == len - 1);
    end
  endtask

  initial begin
    logic [15:0] caps [6];
    int seg_start;
    sb = new();
    caps[0] = 16'hFFFF;
    caps[1] = 16'd0;
    caps[2] = 16'd7;
    caps[3] = 16'($urandom_range(1, 20));
    caps[4] = 16'd1;
    caps[5] = 16'($urandom_range(0, 65535));
    in_gap_pct = 7;
    out_stall_pct = 72;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // clean group, tails, bad char, lone char, non-canonical tails
    send_str("Az0_");
    send_str("-Q");
    send_str("Z8");
    send_str("ZZ9");
    send_str("A");
    send_char(8'hFF, 1'b1);
    send_char(8'h00, 1'b0);
    send_char(b64u_pkg::CH_UA, 1'b1);
    send_str("Z9E");
    // overflow on a full group, then an exact fit
    write_cap(16'd2);
    send_str("TWFu");
    send_str("TWE");

    for (int m = 0; m < 3; m++) begin
      in_gap_pct = (m == 0) ? 7 : (m == 1) ? 72 : 0;
      out_stall_pct = (m == 0) ? 72 : (m == 1) ? 7 : 0;
      for (int s = 0; s < 2; s++) begin
        write_cap(caps[m * 2 + s]);
        seg_start = n_items;
        while (n_items - seg_start < SEG_ITEMS) send_random_token();
      end
    end

    drain();
    repeat (8) @(posedge clk);
    if (sb.errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
